FILE: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the execute stage RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("Assertion failed in execute stage.");

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("Assertion failed in execute stage.");

`endif

FILE: rtl/ceafb_pkg.sv
// ============================================================================
// Execute stage package
// Types, instruction codes and shared arithmetic for the execute stage.
// ============================================================================
package ceafb_pkg;

    localparam int unsigned DataW = 16;

    typedef struct packed {
        logic v;
        logic n;
        logic z;
        logic c;
    } t_flags;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             write;
        logic [DataW-1:0] new_pc;
        logic             taken;
        logic             status;
        t_flags           flags;
    } t_exec;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             c;
        logic             v;
    } t_add;

    localparam logic [2:0] FMT_SINGLE = 3'd0;
    localparam logic [2:0] FMT_JUMP   = 3'd1;

    localparam logic [2:0] SOP_GROUP  = 3'b100;

    localparam logic [1:0] SOP_RRC  = 2'd0;
    localparam logic [1:0] SOP_SWPB = 2'd1;
    localparam logic [1:0] SOP_RRA  = 2'd2;
    localparam logic [1:0] SOP_SXT  = 2'd3;

    localparam logic [3:0] DOP_MOV  = 4'h4;
    localparam logic [3:0] DOP_ADD  = 4'h5;
    localparam logic [3:0] DOP_ADDC = 4'h6;
    localparam logic [3:0] DOP_SUBC = 4'h7;
    localparam logic [3:0] DOP_SUB  = 4'h8;
    localparam logic [3:0] DOP_CMP  = 4'h9;
    localparam logic [3:0] DOP_BIT  = 4'hb;
    localparam logic [3:0] DOP_BIC  = 4'hc;
    localparam logic [3:0] DOP_BIS  = 4'hd;
    localparam logic [3:0] DOP_XOR  = 4'he;
    localparam logic [3:0] DOP_AND  = 4'hf;

    localparam logic [2:0] JC_NE  = 3'd0;
    localparam logic [2:0] JC_EQ  = 3'd1;
    localparam logic [2:0] JC_NC  = 3'd2;
    localparam logic [2:0] JC_C   = 3'd3;
    localparam logic [2:0] JC_N   = 3'd4;
    localparam logic [2:0] JC_GE  = 3'd5;
    localparam logic [2:0] JC_L   = 3'd6;
    localparam logic [2:0] JC_MP  = 3'd7;

    // Operands are expected to be masked to the operand size already.
    function automatic t_add add_op(input logic [DataW-1:0] x, input logic [DataW-1:0] y,
                                    input logic cin, input logic byte_mode);
        logic [DataW:0] s;
        t_add           r;
        s = {1'b0, x} + {1'b0, y} + {{DataW{1'b0}}, cin};
        if (byte_mode) begin
            r.result = {8'h00, s[7:0]};
            r.c      = s[8];
            r.v      = ~(x[7] ^ y[7]) & (x[7] ^ s[7]);
        end else begin
            r.result = s[DataW-1:0];
            r.c      = s[DataW];
            r.v      = ~(x[15] ^ y[15]) & (x[15] ^ s[15]);
        end
        return r;
    endfunction

    function automatic t_flags make_flags(input logic [DataW-1:0] res, input logic byte_mode,
                                          input logic c, input logic v);
        t_flags f;
        f.c = c;
        f.v = v;
        if (byte_mode) begin
            f.z = (res[7:0] == 8'h00);
            f.n = res[7];
        end else begin
            f.z = (res == '0);
            f.n = res[15];
        end
        return f;
    endfunction

endpackage

FILE: rtl/ceafb_exec.sv
// ============================================================================
// Execute logic
// Decodes one instruction and computes its result, next pc and flags.
// ============================================================================
module ceafb_exec (
    input  logic [ceafb_pkg::DataW-1:0] i_instr_word,
    input  logic [ceafb_pkg::DataW-1:0] i_src_value,
    input  logic [ceafb_pkg::DataW-1:0] i_dst_value,
    input  logic [ceafb_pkg::DataW-1:0] i_next_pc,
    input  ceafb_pkg::t_flags           i_flags,
    output ceafb_pkg::t_exec            o_exec
);
    import ceafb_pkg::*;

    always_comb begin
        logic [2:0]       fmt;
        logic             byte_mode;
        logic [DataW-1:0] mask;
        logic [DataW-1:0] sign;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [3:0]       op;
        logic             sub_op;
        logic             cin;
        t_add             sum;
        logic [DataW-1:0] res;
        logic [9:0]       off;
        logic             taken;

        fmt       = i_instr_word[15:13];
        byte_mode = i_instr_word[6];
        mask      = byte_mode ? 16'h00ff : 16'hffff;
        sign      = byte_mode ? 16'h0080 : 16'h8000;
        a         = i_src_value & mask;
        b         = i_dst_value & mask;
        op        = i_instr_word[15:12];
        off       = i_instr_word[9:0];

        sub_op = (op == DOP_SUBC) || (op == DOP_SUB) || (op == DOP_CMP);
        if (op == DOP_ADD) begin
            cin = 1'b0;
        end else if ((op == DOP_SUB) || (op == DOP_CMP)) begin
            cin = 1'b1;
        end else begin
            cin = i_flags.c;
        end
        sum = add_op(b, sub_op ? (~a & mask) : a, cin, byte_mode);

        o_exec        = '0;
        o_exec.new_pc = i_next_pc;
        o_exec.flags  = i_flags;
        res           = '0;
        taken         = 1'b0;

        if (fmt == FMT_JUMP) begin
            unique case (i_instr_word[12:10])
                JC_NE: taken = !i_flags.z;
                JC_EQ: taken = i_flags.z;
                JC_NC: taken = !i_flags.c;
                JC_C:  taken = i_flags.c;
                JC_N:  taken = i_flags.n;
                JC_GE: taken = (i_flags.n == i_flags.v);
                JC_L:  taken = (i_flags.n != i_flags.v);
                JC_MP: taken = 1'b1;
            endcase
            o_exec.taken = taken;
            if (taken) begin
                o_exec.new_pc = i_next_pc + {{5{off[9]}}, off, 1'b0};
            end
        end else if (fmt == FMT_SINGLE) begin
            if ((i_instr_word[12:10] != SOP_GROUP) || i_instr_word[9]) begin
                o_exec.status = 1'b1;
            end else begin
                o_exec.write = 1'b1;
                unique case (i_instr_word[8:7])
                    SOP_RRC: begin
                        res = (a >> 1) | (i_flags.c ? sign : '0);
                        o_exec.flags = make_flags(res, byte_mode, a[0], 1'b0);
                    end
                    SOP_SWPB: begin
                        res = {i_src_value[7:0], i_src_value[15:8]};
                    end
                    SOP_RRA: begin
                        res = (a & sign) | (a >> 1);
                        o_exec.flags = make_flags(res, byte_mode, a[0], 1'b0);
                    end
                    SOP_SXT: begin
                        res = {{8{i_src_value[7]}}, i_src_value[7:0]};
                        o_exec.flags = make_flags(res, 1'b0, res != '0, 1'b0);
                    end
                endcase
                o_exec.result = res;
            end
        end else begin
            o_exec.write = 1'b1;
            case (op)
                DOP_MOV: res = a;
                DOP_ADD, DOP_ADDC, DOP_SUBC, DOP_SUB: begin
                    res = sum.result;
                    o_exec.flags = make_flags(res, byte_mode, sum.c, sum.v);
                end
                DOP_CMP: begin
                    o_exec.flags = make_flags(sum.result, byte_mode, sum.c, sum.v);
                    o_exec.write = 1'b0;
                end
                DOP_BIT: begin
                    o_exec.flags = make_flags(a & b, byte_mode, (a & b) != '0, 1'b0);
                    o_exec.write = 1'b0;
                end
                DOP_BIC: res = b & ~a & mask;
                DOP_BIS: res = b | a;
                DOP_XOR: begin
                    res = a ^ b;
                    o_exec.flags = make_flags(res, byte_mode, res != '0,
                                              ((a & b & sign) != '0));
                end
                DOP_AND: begin
                    res = a & b;
                    o_exec.flags = make_flags(res, byte_mode, res != '0, 1'b0);
                end
                default: begin
                    o_exec.write  = 1'b0;
                    o_exec.status = 1'b1;
                end
            endcase
            o_exec.result = res;
        end
    end

endmodule

FILE: rtl/cpu_execute_alu_flags_branch.sv
// Execute stage of a 16-bit processor. Each input transaction carries an
// instruction word with its fetched operands and the following pc, and yields
// exactly one output transaction with the result, write-enable, next pc, jump
// decision, the flags after the instruction and a status bit. A transaction is
// registered on entry, executed by the combinational execute logic and
// registered again on exit, where the output register presents its result;
// one transaction is taken every cycle while the output side does not stall.
// The carry, zero, negative and overflow flags are updated as each
// transaction leaves the execute logic and are seen by the next one; they
// reset to zero.
// ============================================================================
// Execute stage top level
// Input register, execute logic, flag register and output register.
// ============================================================================
`include "assert_macros.svh"

module cpu_execute_alu_flags_branch (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ceafb_pkg::DataW-1:0] i_instr_word,
    input  logic [ceafb_pkg::DataW-1:0] i_src_value,
    input  logic [ceafb_pkg::DataW-1:0] i_dst_value,
    input  logic [ceafb_pkg::DataW-1:0] i_next_pc,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ceafb_pkg::DataW-1:0] o_result_value,
    output logic                        o_write_result,
    output logic [ceafb_pkg::DataW-1:0] o_new_pc,
    output logic                        o_jump_taken,
    output logic                        o_carry_out,
    output logic                        o_zero_out,
    output logic                        o_negative_out,
    output logic                        o_overflow_out,
    output logic                        o_status
);
    import ceafb_pkg::*;

    logic             r_in_valid;
    logic [DataW-1:0] r_instr_word;
    logic [DataW-1:0] r_src_value;
    logic [DataW-1:0] r_dst_value;
    logic [DataW-1:0] r_next_pc;
    logic             r_out_valid;
    t_exec            r_out;
    t_flags           r_flags;
    t_exec            n_exec;
    logic             advance;
    logic             fire;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    ceafb_exec u_exec (
        .i_instr_word (r_instr_word),
        .i_src_value  (r_src_value),
        .i_dst_value  (r_dst_value),
        .i_next_pc    (r_next_pc),
        .i_flags      (r_flags),
        .o_exec       (n_exec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_flags <= n_exec.flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_instr_word <= i_instr_word;
            r_src_value  <= i_src_value;
            r_dst_value  <= i_dst_value;
            r_next_pc    <= i_next_pc;
        end
        if (fire) begin
            r_out <= n_exec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out.result;
    assign o_write_result = r_out.write;
    assign o_new_pc       = r_out.new_pc;
    assign o_jump_taken   = r_out.taken;
    assign o_carry_out    = r_out.flags.c;
    assign o_zero_out     = r_out.flags.z;
    assign o_negative_out = r_out.flags.n;
    assign o_overflow_out = r_out.flags.v;
    assign o_status       = r_out.status;

    `ASSERT_ALWAYS(a_flags_reset, i_clk, !i_rst_n |=> (r_flags == '0))
    `ASSERT_CLK(a_flags_hold, i_clk, i_rst_n, !fire |=> $stable(r_flags))
    `ASSERT_CLK(a_out_flags_match, i_clk, i_rst_n, fire |=> (r_out.flags == r_flags))
    `ASSERT_CLK(a_unhandled_quiet, i_clk, i_rst_n,
                (r_out_valid && r_out.status) |-> (!r_out.write && !r_out.taken))
    `ASSERT_CLK(a_jump_no_write, i_clk, i_rst_n,
                (r_out_valid && r_out.taken) |-> !r_out.write)

endmodule
